FILE: rtl/c8_pkg.sv
`default_nettype none
package c8_pkg;

    localparam int unsigned MEM_AW = 12;
    localparam int unsigned SCR_AW = 5;
    localparam int unsigned SCR_W  = 64;

    localparam logic [MEM_AW-1:0] FONT_BASE = 12'h050;
    localparam logic [MEM_AW-1:0] FONT_END  = 12'h0A0;
    localparam logic [MEM_AW-1:0] PC_RESET  = 12'h200;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_ROW  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [3:0] OP_CLS = 4'h0;
    localparam logic [3:0] OP_JP  = 4'h1;
    localparam logic [3:0] OP_LD  = 4'h6;
    localparam logic [3:0] OP_ADD = 4'h7;
    localparam logic [3:0] OP_LDI = 4'hA;
    localparam logic [3:0] OP_DRW = 4'hD;

    localparam logic [7:0] FONT_GLYPHS [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic {
        ALU_ADD,
        ALU_SHR
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [MEM_AW-1:0] a;
        logic [MEM_AW-1:0] b;
    } t_alu_req;

    function automatic logic [7:0] f_font_byte(input logic [MEM_AW-1:0] addr);
        logic [MEM_AW-1:0] off;
        off = addr - FONT_BASE;
        if (addr >= FONT_BASE && addr < FONT_END) begin
            return FONT_GLYPHS[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/c8_alu.sv
`default_nettype none
module c8_alu
    import c8_pkg::*;
(
    input  wire t_alu_req         i_req,
    output logic [SCR_W-1:0]      o_res
);

    always_comb begin
        unique case (i_req.op)
            ALU_ADD: o_res = {{(SCR_W-MEM_AW){1'b0}}, i_req.a + i_req.b};
            ALU_SHR: o_res = {i_req.b[7:0], {(SCR_W-8){1'b0}}} >> i_req.a[5:0];
            default: o_res = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/c8_mem.sv
`default_nettype none
module c8_mem
    import c8_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_we,
    input  wire  [MEM_AW-1:0] i_addr,
    input  wire  [7:0]        i_wdata,
    output logic [7:0]        o_rdata,
    output logic              o_init_done
);

    logic [7:0]        r_mem [2**MEM_AW];
    logic [7:0]        r_rdata;
    logic              r_busy;
    logic [MEM_AW-1:0] r_init_addr;

    // init sweep: zero fill with font glyphs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_init_addr <= '0;
        end else if (r_busy) begin
            r_init_addr <= r_init_addr + 1'b1;
            if (&r_init_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_init_addr] <= f_font_byte(r_init_addr);
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata     = r_rdata;
    assign o_init_done = !r_busy;

endmodule
`default_nettype wire

FILE: rtl/c8_scr.sv
`default_nettype none
module c8_scr
    import c8_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_clr,
    input  wire               i_we,
    input  wire  [SCR_AW-1:0] i_waddr,
    input  wire  [SCR_W-1:0]  i_wdata,
    input  wire  [SCR_AW-1:0] i_raddr,
    output logic [SCR_W-1:0]  o_rdata
);

    logic [SCR_W-1:0]     r_rows [2**SCR_AW];
    logic [2**SCR_AW-1:0] r_vld;
    logic [SCR_W-1:0]     r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_raddr];
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rows[i_waddr] <= i_wdata;
        end
        r_rdata <= r_rows[i_raddr];
    end

    // unwritten or cleared rows read as blank
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule
`default_nettype wire

FILE: rtl/chip8_subset_interpreter_core.sv
`default_nettype none
// CHIP-8 subset interpreter. Each request loads a memory byte, reads one
// display row, or runs one fetch-decode-execute step (CLS for any 0NNN, JP,
// LD Vx, ADD Vx, LD I, DRW); other opcodes return status 1. After reset the
// block fills its 4096-byte memory with zeros and the hex font at 0x050, one
// byte per cycle, and stays not ready until that sweep is done. A draw stops
// early when clipped at the bottom edge of the display. Every byte goes
// through the single port of main memory with a registered read, and one
// shared ALU does the program counter, register add and sprite shift. A
// finished result waits in the output register while the next request is
// taken. An ACT_NONE request runs no operation and just returns a result.
module chip8_subset_interpreter_core
    import c8_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [1:0]        i_action,
    input  wire  [11:0]       i_load_address,
    input  wire  [7:0]        i_load_byte,
    input  wire  [4:0]        i_row_select,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [63:0]       o_row_pixels,
    output logic [11:0]       o_program_counter,
    output logic [7:0]        o_flag_register,
    output logic              o_status
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FETCH_HI = 4'd1;
    localparam logic [3:0] S_FETCH_LO = 4'd2;
    localparam logic [3:0] S_OP_LO    = 4'd3;
    localparam logic [3:0] S_EXEC     = 4'd4;
    localparam logic [3:0] S_DRAW_X   = 4'd5;
    localparam logic [3:0] S_DRAW_Y   = 4'd6;
    localparam logic [3:0] S_DRAW_RD  = 4'd7;
    localparam logic [3:0] S_DRAW_WR  = 4'd8;
    localparam logic [3:0] S_ROW      = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    localparam logic [3:0] VF = 4'hF;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [MEM_AW-1:0] r_pc;
    logic [MEM_AW-1:0] r_index;
    logic [7:0]        r_v [16];
    logic              r_status;
    logic              r_ovalid;

    logic [15:0]       r_op;
    logic [5:0]        r_xpos;
    logic [SCR_AW:0]   r_line;
    logic [3:0]        r_cnt;
    logic [MEM_AW-1:0] r_sp_addr;
    logic [SCR_W-1:0]  r_row_res;
    logic [SCR_W-1:0]  r_out_row;
    logic [MEM_AW-1:0] r_out_pc;
    logic [7:0]        r_out_vf;
    logic              r_out_status;

    logic              accept;
    logic              init_done;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_rdata;
    logic              scr_clr;
    logic              scr_we;
    logic [SCR_AW-1:0] scr_raddr;
    logic [SCR_W-1:0]  scr_rdata;
    t_alu_req          alu_req;
    logic [SCR_W-1:0]  alu_res;
    logic [3:0]        reg_sel;
    logic [7:0]        reg_rd;
    logic              collide;
    logic              draw_done;
    logic              out_load;

    c8_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (mem_we),
        .i_addr      (mem_addr),
        .i_wdata     (i_load_byte),
        .o_rdata     (mem_rdata),
        .o_init_done (init_done)
    );

    c8_scr u_scr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (scr_clr),
        .i_we    (scr_we),
        .i_waddr (r_line[SCR_AW-1:0]),
        .i_wdata (scr_rdata ^ alu_res),
        .i_raddr (scr_raddr),
        .o_rdata (scr_rdata)
    );

    c8_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign o_ready   = (r_state == S_IDLE) && init_done;
    assign accept    = i_valid && o_ready;
    assign reg_rd    = r_v[reg_sel];
    assign collide   = |(scr_rdata & alu_res);
    assign draw_done = (r_cnt == r_op[3:0]) || r_line[SCR_AW];
    assign out_load  = (r_state == S_FIN) && (!r_ovalid || i_ready);

    always_comb begin
        mem_addr  = r_pc;
        mem_we    = 1'b0;
        scr_raddr = i_row_select;
        scr_we    = 1'b0;
        scr_clr   = 1'b0;
        reg_sel   = r_op[11:8];
        alu_req   = '{op: ALU_ADD, a: r_pc, b: 12'd1};
        unique case (r_state)
            S_IDLE: begin
                mem_addr = i_load_address;
                mem_we   = accept && (i_action == ACT_LOAD);
            end
            S_FETCH_LO: mem_addr = alu_res[MEM_AW-1:0];
            S_OP_LO:    alu_req.b = 12'd2;
            S_EXEC: begin
                if (r_op[15:12] == OP_ADD) begin
                    alu_req = '{op: ALU_ADD, a: {4'd0, reg_rd}, b: {4'd0, r_op[7:0]}};
                end
                scr_clr = (r_op[15:12] == OP_CLS);
            end
            S_DRAW_Y: reg_sel = r_op[7:4];
            S_DRAW_RD: begin
                mem_addr  = r_sp_addr;
                scr_raddr = r_line[SCR_AW-1:0];
            end
            S_DRAW_WR: begin
                alu_req = '{op: ALU_SHR, a: {6'd0, r_xpos}, b: {4'd0, mem_rdata}};
                scr_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_STEP: n_state = S_FETCH_HI;
                        ACT_ROW:  n_state = S_ROW;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_FETCH_HI: n_state = S_FETCH_LO;
            S_FETCH_LO: n_state = S_OP_LO;
            S_OP_LO:    n_state = S_EXEC;
            S_EXEC:     n_state = (r_op[15:12] == OP_DRW) ? S_DRAW_X : S_FIN;
            S_DRAW_X:   n_state = S_DRAW_Y;
            S_DRAW_Y:   n_state = S_DRAW_RD;
            S_DRAW_RD:  n_state = draw_done ? S_FIN : S_DRAW_WR;
            S_DRAW_WR:  n_state = S_DRAW_RD;
            S_ROW:      n_state = S_FIN;
            S_FIN:      n_state = out_load ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= PC_RESET;
            r_index  <= '0;
            r_status <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                r_v[k] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= 1'b0;
                    end
                end
                S_OP_LO: r_pc <= alu_res[MEM_AW-1:0];
                S_EXEC: begin
                    unique case (r_op[15:12]) inside
                        OP_CLS, OP_DRW: ;
                        OP_JP:   r_pc <= r_op[11:0];
                        OP_LD:   r_v[r_op[11:8]] <= r_op[7:0];
                        OP_ADD:  r_v[r_op[11:8]] <= alu_res[7:0];
                        OP_LDI:  r_index <= r_op[11:0];
                        default: r_status <= 1'b1;
                    endcase
                end
                S_DRAW_Y: r_v[VF] <= 8'd0;
                S_DRAW_WR: begin
                    if (collide) begin
                        r_v[VF] <= 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_row_res <= '0;
                end
            end
            S_FETCH_LO: r_op[15:8] <= mem_rdata;
            S_OP_LO:    r_op[7:0]  <= mem_rdata;
            S_DRAW_X:   r_xpos     <= reg_rd[5:0];
            S_DRAW_Y: begin
                r_line    <= {1'b0, reg_rd[SCR_AW-1:0]};
                r_cnt     <= 4'd0;
                r_sp_addr <= r_index;
            end
            S_DRAW_WR: begin
                r_line    <= r_line + 1'b1;
                r_cnt     <= r_cnt + 1'b1;
                r_sp_addr <= r_sp_addr + 1'b1;
            end
            S_ROW: r_row_res <= scr_rdata;
            default: ;
        endcase
        if (out_load) begin
            r_out_row    <= r_row_res;
            r_out_pc     <= r_pc;
            r_out_vf     <= r_v[VF];
            r_out_status <= r_status;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_row_pixels      = r_out_row;
    assign o_program_counter = r_out_pc;
    assign o_flag_register   = r_out_vf;
    assign o_status          = r_out_status;

    a_pc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OP_LO) |=> (r_pc == ($past(r_pc) + 12'd2)))
        else $error("pc did not advance by two on fetch");

    a_draw_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW_WR) |-> (r_cnt < r_op[3:0]) && !r_line[SCR_AW])
        else $error("sprite row drawn past height or screen edge");

    a_vf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && $past(r_state) == S_DRAW_RD) |-> (r_v[VF] <= 8'd1))
        else $error("collision flag not 0 or 1 after draw");

endmodule
`default_nettype wire
